>>> design/rwc_pkg.sv
// shared types and constants for the replay window check
`default_nettype none

package rwc_pkg;

	localparam int WORD_BITS       = 64;
	localparam int WINDOW_BITS_DEF = 1024;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SEEN  = 2'd1,
		ST_OLD   = 2'd2,
		ST_ORDER = 2'd3
	} status_t;

	typedef struct packed {
		logic    ok;
		status_t status;
	} judge_t;

endpackage

`default_nettype wire

>>> design/rwc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module rwc_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

>>> design/rwc_judge.sv
// freshness decision for one counter against the window
`default_nettype none

module rwc_judge import rwc_pkg::*; #(
	parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
	input  wire logic [31:0]          back,
	input  wire logic                 allow_ooo,
	input  wire logic [WORD_BITS-1:0] word,
	output judge_t                    result
);

	always_comb begin
		// top bit of the backward distance set means the counter is newer
		if (back[31]) begin
			result.status = ST_OK;
		end else if (!allow_ooo) begin
			result.status = ST_ORDER;
		end else if (back >= 32'(WINDOW_BITS)) begin
			result.status = ST_OLD;
		end else if (word[back[5:0]]) begin
			result.status = ST_SEEN;
		end else begin
			result.status = ST_OK;
		end
		result.ok = (result.status == ST_OK);
	end

endmodule

`default_nettype wire

>>> design/rwc_ctrl.sv
// sequencer: bitmap read-modify-write, window slide sweep and result register
`default_nettype none

module rwc_ctrl import rwc_pkg::*; #(
	parameter int WINDOW_BITS = WINDOW_BITS_DEF,
	parameter int WORDS       = (WINDOW_BITS + WORD_BITS - 1) / WORD_BITS,
	parameter int AW          = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 req_type,
	input  wire logic [63:0]          counter,
	input  wire logic                 allow_ooo,
	output logic                      busy,
	output logic                      done,
	output logic                      fresh,
	output logic [1:0]                status,
	output logic                      mem_wr_en,
	output logic [AW-1:0]             mem_wr_addr,
	output logic [WORD_BITS-1:0]      mem_wr_data,
	output logic [AW-1:0]             mem_rd_addr,
	input  wire logic [WORD_BITS-1:0] mem_rd_data
);

	localparam int VBITS = 1 << AW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_PRIME,
		S_SHIFT,
		S_FIN
	} state_t;

	state_t               state_q;
	logic                 done_q;
	logic                 fresh_q;
	status_t              status_q;
	logic [63:0]          newest_q;
	logic [VBITS-1:0]     valid_q;
	logic [VBITS-1:0]     valid_d;
	logic                 rvalid_s1;

	logic                 req_q;
	logic [63:0]          counter_q;
	logic [31:0]          back_q;
	logic [WORD_BITS-1:0] hi_q;
	logic [AW-1:0]        src_q;

	logic [31:0]          back_in;
	logic [31:0]          fwd;
	logic [AW-1:0]        ws;
	logic [5:0]           bs;
	logic [AW-1:0]        src_top;
	logic [AW-1:0]        dst;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] lo_word;
	logic [2*WORD_BITS-1:0] merged;
	logic [VBITS-1:0]     low_mask;
	logic                 restart;
	logic                 commit_ok;
	judge_t               jd;

	assign back_in = newest_q[31:0] - counter[31:0];
	assign fwd     = 32'd0 - back_q;
	assign ws      = fwd[6 +: AW];
	assign bs      = fwd[5:0];
	assign src_top = AW'(WORDS - 1) - ws;
	assign dst     = src_q + ws;
	assign rd_word = rvalid_s1 ? mem_rd_data : '0;
	// the lowest source word has nothing below it to pull bits from
	assign lo_word = (src_q == '0) ? '0 : rd_word;
	assign merged  = {hi_q, lo_word} << bs;
	assign restart = fwd >= 32'(WINDOW_BITS);
	assign commit_ok = req_q && jd.ok;

	always_comb begin
		for (int i = 0; i < VBITS; i++) begin
			low_mask[i] = (i < int'(ws));
		end
	end

	rwc_judge #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_judge (
		.back     (back_q),
		.allow_ooo(allow_ooo),
		.word     (rd_word),
		.result   (jd)
	);

	always_comb begin
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = '0;
		mem_wr_data = '0;
		valid_d     = valid_q;
		unique case (state_q)
			S_IDLE: begin
				mem_rd_addr = back_in[6 +: AW];
			end
			S_LOOK: begin
				mem_rd_addr = src_top;
				if (commit_ok) begin
					if (back_q[31]) begin
						if (restart) begin
							mem_wr_en      = 1'b1;
							mem_wr_data    = WORD_BITS'(1);
							valid_d        = '0;
							valid_d[0]     = 1'b1;
						end
					end else begin
						mem_wr_en   = 1'b1;
						mem_wr_addr = back_q[6 +: AW];
						mem_wr_data = rd_word | (WORD_BITS'(1) << back_q[5:0]);
						valid_d[back_q[6 +: AW]] = 1'b1;
					end
				end
			end
			S_PRIME: begin
				mem_rd_addr = src_top - AW'(1);
			end
			S_SHIFT: begin
				mem_rd_addr = src_q - AW'(1) - AW'(1);
				mem_wr_en   = 1'b1;
				mem_wr_addr = dst;
				mem_wr_data = merged[2*WORD_BITS-1:WORD_BITS];
				// no word move: the newest counter bit lands in this last word
				if (src_q == '0 && ws == '0) begin
					mem_wr_data[0] = 1'b1;
				end
				valid_d[dst] = 1'b1;
				if (src_q == '0) begin
					valid_d = valid_d & ~low_mask;
				end
			end
			S_FIN: begin
				mem_wr_en   = 1'b1;
				mem_wr_data = WORD_BITS'(1);
				valid_d[0]  = 1'b1;
			end
			default: begin
				mem_rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			fresh_q   <= 1'b0;
			status_q  <= ST_OK;
			newest_q  <= '0;
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			valid_q   <= valid_d;
			rvalid_s1 <= valid_q[mem_rd_addr];
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					done_q   <= 1'b1;
					fresh_q  <= jd.ok;
					status_q <= jd.status;
					state_q  <= S_IDLE;
					if (commit_ok && back_q[31]) begin
						newest_q <= counter_q;
						if (!restart) begin
							state_q <= S_PRIME;
						end
					end
				end
				S_PRIME: begin
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (src_q == '0) begin
						state_q <= (ws == '0) ? S_IDLE : S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q     <= req_type;
					counter_q <= counter;
					back_q    <= back_in;
				end
			end
			S_PRIME: begin
				hi_q  <= rd_word;
				src_q <= src_top;
			end
			S_SHIFT: begin
				hi_q  <= rd_word;
				src_q <= src_q - AW'(1);
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign fresh  = fresh_q;
	assign status = status_q;

endmodule

`default_nettype wire

>>> design/replay_window_check_core.sv
// Anti-replay window over 64-bit packet counters. A request is taken when start is high and
// busy is low; its result shows on fresh and status for one cycle with done high, registered
// from S_LOOK, and the receiver cannot stall it. A check, a refused request, an older-counter
// commit and a commit that jumps the window by WINDOW_BITS or more all return to idle from
// S_LOOK; busy drops in the cycle done is shown. A commit of a newer counter closer than
// WINDOW_BITS moves the bitmap through its ram one 64-bit word per cycle, so busy stays high
// through S_PRIME, the S_SHIFT sweep and, when the window moves a whole word or more, S_FIN.
// A valid flag per bitmap word makes every word read as zero after reset, so there is no
// clearing pass and a request may come on the first cycle after reset.
`default_nettype none

module replay_window_check_core import rwc_pkg::*; #(
	parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        req_type,
	input  wire logic [63:0] counter,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	output logic             done,
	output logic             fresh,
	output logic [1:0]       status
);

	localparam int WORDS = (WINDOW_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic                 allow_ooo_q;
	logic                 mem_wr_en;
	logic [AW-1:0]        mem_wr_addr;
	logic [WORD_BITS-1:0] mem_wr_data;
	logic [AW-1:0]        mem_rd_addr;
	logic [WORD_BITS-1:0] mem_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_ooo_q <= 1'b1;
		end else if (cfg_wr_en) begin
			allow_ooo_q <= cfg_wr_data;
		end
	end

	rwc_ctrl #(
		.WINDOW_BITS(WINDOW_BITS),
		.WORDS      (WORDS),
		.AW         (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.counter    (counter),
		.allow_ooo  (allow_ooo_q),
		.busy       (busy),
		.done       (done),
		.fresh      (fresh),
		.status     (status),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	rwc_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORDS),
		.ADDR_W(AW)
	) u_bitmap (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	// every taken request gets its result strobe
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("request without result two cycles later");

	// a result only follows a request in progress
	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	a_fresh_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (fresh == (status == ST_OK)))
		else $error("fresh disagrees with status");

	// no write to the bitmap while idle
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !mem_wr_en)
		else $error("bitmap write while idle");

endmodule

`default_nettype wire
